/* design/eft_pkg.sv */
// ----------------------------------------------------------------------------
// eft_pkg
// Shared types and codes for the event flag table.
// ----------------------------------------------------------------------------
package eft_pkg;

  localparam int KIND_W     = 3;
  localparam int ID_W       = 16;
  localparam int WORD_W     = 32;
  localparam int NEW_ID_W   = 8;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 48;

  localparam logic [KIND_W-1:0] KIND_CREATE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SET    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_WAIT   = 3'd4;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // one table entry as held in the RAM
  typedef struct packed {
    logic              used;
    logic              auto_clear;
    logic [WORD_W-1:0] bits;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

/* design/eft_ram.sv */
// ----------------------------------------------------------------------------
// eft_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module eft_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/event_flag_table_top.sv */
// ----------------------------------------------------------------------------
// event_flag_table_top
// Table of 32-bit event flag words with create, delete, set, clear and wait.
//
//   channel  dir  tdata (low bit up)                               tuser
//   s_*      in   flag_id[15:0] bit_pattern[47:16] and_mode[48]     kind[2:0]
//                 auto_clear[49], zero[55:50]
//   m_*      out  status[0] new_id[8:1] flag_word[40:9]              -
//                 satisfied[41], zero[47:42]
//
// One request per cycle while m_tready does not stall the result; the entry
// RAM is read at the accepting edge, then the entry is modified and written
// back while the result register loads and m_tvalid rises.
// A write to the entry read by the next request is forwarded around the RAM.
// Entries are known valid by the identifier counter plus a used mark held in
// the RAM, so no clearing pass is needed after reset.
// A stalled m_tready holds the result and back-pressures s_tready.
// ----------------------------------------------------------------------------
module event_flag_table_top
  import eft_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // flag_id, bit_pattern, and_mode, auto_clear
  input  logic [KIND_W-1:0]     s_tuser,   // kind
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // status, new_id, flag_word, satisfied
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // request register
  logic              s1_valid;
  logic [KIND_W-1:0] s1_kind;
  logic [ID_W-1:0]   s1_id;
  logic [WORD_W-1:0] s1_pat;
  logic              s1_and_mode;
  logic              s1_auto_clear;
  logic              fwd_hit;
  entry_t            fwd_data;

  logic [CW-1:0]     next_id;
  logic [CW-1:0]     next_id_next;

  logic              advance;
  logic              accept;
  logic [ID_W-1:0]   in_id;
  logic [AW-1:0]     in_idx;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  entry_t            wr_data;
  logic [ENTRY_W-1:0] rd_raw;
  entry_t            ent;

  logic                id_ok;
  logic                ok;
  logic                res_status;
  logic [NEW_ID_W-1:0] res_new_id;
  logic [WORD_W-1:0]   res_word;
  logic                res_sat;

  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;
  assign accept   = s_tvalid && s_tready;
  assign in_id    = s_tdata[ID_W-1:0];
  assign in_idx   = in_id[AW-1:0];

  eft_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (in_idx),
    .rd_data (rd_raw)
  );

  assign ent = fwd_hit ? fwd_data : entry_t'(rd_raw);

  // entry 0 is never created; created entries all lie below the counter
  assign id_ok = (s1_id != '0) && ((ID_W + 1)'(s1_id) < (ID_W + 1)'(next_id)) && ent.used;
  assign ok    = s1_and_mode ? ((ent.bits & s1_pat) == s1_pat) : |(ent.bits & s1_pat);

  always_comb begin
    wr_en        = 1'b0;
    wr_addr      = s1_id[AW-1:0];
    wr_data      = ent;
    next_id_next = next_id;
    res_status   = STATUS_ERR;
    res_new_id   = '0;
    res_word     = '0;
    res_sat      = 1'b0;
    unique case (s1_kind)
      KIND_CREATE: begin
        if (next_id < DEPTH_C) begin
          wr_en        = advance;
          wr_addr      = next_id[AW-1:0];
          wr_data      = '{used: 1'b1, auto_clear: s1_auto_clear, bits: s1_pat};
          next_id_next = next_id + CW'(1);
          res_status   = STATUS_OK;
          res_new_id   = NEW_ID_W'(next_id);
        end
      end
      KIND_DELETE: begin
        if (id_ok) begin
          wr_en      = advance;
          wr_data    = '0;
          res_status = STATUS_OK;
        end
      end
      KIND_SET: begin
        if (id_ok) begin
          wr_en        = advance;
          wr_data.bits = ent.bits | s1_pat;
          res_status   = STATUS_OK;
        end
      end
      KIND_CLEAR: begin
        if (id_ok) begin
          wr_en        = advance;
          wr_data.bits = ent.bits & s1_pat;
          res_status   = STATUS_OK;
        end
      end
      KIND_WAIT: begin
        if (id_ok) begin
          wr_en        = advance;
          wr_data.bits = (ok && ent.auto_clear) ? (ent.bits & ~s1_pat) : ent.bits;
          res_status   = STATUS_OK;
          res_word     = ent.bits;
          res_sat      = ok;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
      next_id  <= CW'(1);
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
        next_id  <= next_id_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind       <= s_tuser;
      s1_id         <= in_id;
      s1_pat        <= s_tdata[ID_W +: WORD_W];
      s1_and_mode   <= s_tdata[ID_W + WORD_W];
      s1_auto_clear <= s_tdata[ID_W + WORD_W + 1];
      // RAM read coincides with this write: take the new value instead
      fwd_hit       <= wr_en && (wr_addr == in_idx);
      fwd_data      <= wr_data;
    end
    if (advance) begin
      m_tdata <= {(OUT_DATA_W - 2 - NEW_ID_W - WORD_W)'(0), res_sat, res_word,
                  res_new_id, res_status};
    end
  end

  a_counter_range: assert property (@(posedge clk) disable iff (rst)
    (next_id != '0) && (next_id <= DEPTH_C))
    else $error("identifier counter out of range");

  a_counter_on_create: assert property (@(posedge clk) disable iff (rst)
    (next_id != $past(next_id)) |-> $past(wr_en && (s1_kind == KIND_CREATE)))
    else $error("identifier counter moved without a create");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[0] == STATUS_ERR)) |-> (m_tdata[OUT_DATA_W-1:1] == '0))
    else $error("error result carries data");

  a_fwd_needs_write: assert property (@(posedge clk) disable iff (rst)
    (accept && !wr_en) |=> !fwd_hit)
    else $error("forward taken without a write");

endmodule

/* tb/sv/event_flag_table_top_test.sv */
// ----------------------------------------------------------------------------
// event_flag_table_top_test
// Self-checking bench for the event flag table. Requests are queued by an
// initial block and driven in bursts of random length. The result side
// stalls in changing patterns. Each accepted request runs through a
// behavioural copy of the table, and the outcome is queued. Every result
// is checked field by field against the oldest queued outcome.
// A directed opening covers id zero, unissued and out-of-range ids, kinds
// 5 to 7, empty and full patterns, auto-clear, and delete. A random part
// follows, then enough creates to exhaust the table.
// ----------------------------------------------------------------------------
module event_flag_table_top_test;
  import eft_pkg::*;

  localparam int TABLE_DEPTH  = 256;
  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_OPS   = 1030;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   flag_id;
    logic [WORD_W-1:0] pattern;
    logic              and_mode;
    logic              auto_clear;
    bit                drain;     // hold until every outcome has come back
  } flag_req_t;

  typedef struct {
    logic                status;
    logic [NEW_ID_W-1:0] new_id;
    logic [WORD_W-1:0]   word;
    logic                satisfied;
  } flag_resp_t;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PULSE} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;  // flag_id, bit_pattern, and_mode, auto_clear
  logic [KIND_W-1:0]     s_tuser = '0;  // kind
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;       // status, new_id, flag_word, satisfied

  // behavioural copy of the table
  bit [WORD_W-1:0] word_mirror [TABLE_DEPTH];
  bit              clear_mirror [TABLE_DEPTH];
  bit              used_mirror [TABLE_DEPTH];
  int              id_counter = 1;

  flag_req_t  op_queue [$];
  flag_resp_t due_outcomes [$];
  flag_req_t  in_flight;

  // generator view of which ids are live
  int gen_next = 1;
  int gen_live [$];
  int last_id = 0;

  int burst_left = 1;
  int gap_left = 0;
  rx_mode_t rx_mode = RX_FREE;
  int rx_span = 0;
  int unsigned cycle_count = 0;

  int n_sent = 0;
  int n_results = 0;
  int n_err_status = 0;
  int n_satisfied = 0;
  int refused_creates = 0;
  int mismatch_count = 0;

  event_flag_table_top #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic flag_resp_t apply_flag_op(input flag_req_t r);
    flag_resp_t        o;
    logic              live;
    logic [WORD_W-1:0] cur;
    logic              met;
    o.status = STATUS_ERR;
    o.new_id = '0;
    o.word = '0;
    o.satisfied = 1'b0;
    live = 1'b0;
    if (r.flag_id < TABLE_DEPTH) live = used_mirror[r.flag_id];
    case (r.kind)
      KIND_CREATE: begin
        if (id_counter < TABLE_DEPTH) begin
          word_mirror[id_counter] = r.pattern;
          clear_mirror[id_counter] = r.auto_clear;
          used_mirror[id_counter] = 1'b1;
          o.status = STATUS_OK;
          o.new_id = NEW_ID_W'(id_counter);
          id_counter++;
        end else begin
          refused_creates++;
        end
      end
      KIND_DELETE: begin
        if (live) begin
          word_mirror[r.flag_id] = '0;
          clear_mirror[r.flag_id] = 1'b0;
          used_mirror[r.flag_id] = 1'b0;
          o.status = STATUS_OK;
        end
      end
      KIND_SET: begin
        if (live) begin
          word_mirror[r.flag_id] = word_mirror[r.flag_id] | r.pattern;
          o.status = STATUS_OK;
        end
      end
      KIND_CLEAR: begin
        if (live) begin
          word_mirror[r.flag_id] = word_mirror[r.flag_id] & r.pattern;
          o.status = STATUS_OK;
        end
      end
      KIND_WAIT: begin
        if (live) begin
          cur = word_mirror[r.flag_id];
          met = r.and_mode ? ((cur & r.pattern) == r.pattern) : ((cur & r.pattern) != '0);
          if (met && clear_mirror[r.flag_id]) word_mirror[r.flag_id] = cur & ~r.pattern;
          o.status = STATUS_OK;
          o.word = cur;
          o.satisfied = met;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("mismatch at result %0d, %s: got 0x%0h, want 0x%0h",
             n_results, what, got, want);
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] d);
    flag_resp_t want;
    if (due_outcomes.size() == 0) begin
      report_mismatch("unexpected result", 64'(d), 64'd0);
    end else begin
      want = due_outcomes.pop_front();
      if (d[0] !== want.status)
        report_mismatch("status", 64'(d[0]), 64'(want.status));
      if (d[8:1] !== want.new_id)
        report_mismatch("new_id", 64'(d[8:1]), 64'(want.new_id));
      if (d[40:9] !== want.word)
        report_mismatch("flag_word", 64'(d[40:9]), 64'(want.word));
      if (d[41] !== want.satisfied)
        report_mismatch("satisfied", 64'(d[41]), 64'(want.satisfied));
      if (want.status == STATUS_ERR) n_err_status++;
      if (want.satisfied) n_satisfied++;
    end
    n_results++;
  endtask

  task automatic push_req(input logic [KIND_W-1:0] kind, input int id,
                          input logic [WORD_W-1:0] pattern, input logic and_mode,
                          input logic auto_clear, input bit drain);
    flag_req_t r;
    r.kind = kind;
    r.flag_id = ID_W'(id);
    r.pattern = pattern;
    r.and_mode = and_mode;
    r.auto_clear = auto_clear;
    r.drain = drain;
    op_queue.push_back(r);
    if (kind == KIND_CREATE) begin
      if (gen_next < TABLE_DEPTH) begin
        gen_live.push_back(gen_next);
        last_id = gen_next;
        gen_next++;
      end
    end else begin
      last_id = id;
      if (kind == KIND_DELETE) begin
        for (int i = 0; i < gen_live.size(); i++) begin
          if (gen_live[i] == id) begin
            gen_live.delete(i);
            break;
          end
        end
      end
    end
  endtask

  function automatic int pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30 && last_id > 0 && last_id < TABLE_DEPTH) return last_id;
    if (r < 80 && gen_live.size() != 0) return gen_live[$urandom_range(0, gen_live.size() - 1)];
    if (r < 84) return 0;
    if (r < 88 && gen_next < TABLE_DEPTH) return $urandom_range(gen_next, TABLE_DEPTH - 1);
    if (r < 94 || gen_next < 2) return $urandom_range(TABLE_DEPTH, 65535);
    return $urandom_range(1, gen_next - 1);
  endfunction

  function automatic logic [WORD_W-1:0] pick_pattern();
    logic [WORD_W-1:0] p;
    case ($urandom_range(0, 5))
      0: p = $urandom;
      1: p = 32'd1 << $urandom_range(0, 31);
      2: p = (32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31))
             | (32'd1 << $urandom_range(0, 31));
      3: p = '0;
      4: p = '1;
      default: p = $urandom & $urandom;
    endcase
    return p;
  endfunction

  // sender: bursts with gaps, one request held until accepted
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        due_outcomes.push_back(apply_flag_op(in_flight));
        n_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (op_queue.size() == 0 ||
                     (op_queue[0].drain && due_outcomes.size() != 0)) begin
          s_tvalid <= 1'b0;
        end else begin
          in_flight = op_queue.pop_front();
          s_tdata <= {6'b0, in_flight.auto_clear, in_flight.and_mode,
                      in_flight.pattern, in_flight.flag_id};
          s_tuser <= in_flight.kind;
          s_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(60, 150);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 20);
            gap_left = $urandom_range(0, 10);
          end
        end
      end
    end
  end

  // receiver: check results, with a stall pattern that changes over the run
  always @(posedge clk) begin
    cycle_count++;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_result(m_tdata);
      if (rx_span == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_span = $urandom_range(50, 300);
      end else begin
        rx_span--;
      end
      case (rx_mode)
        RX_FREE:  m_tready <= 1'b1;
        RX_LIGHT: m_tready <= ($urandom_range(0, 9) < 7);
        RX_HEAVY: m_tready <= ($urandom_range(0, 3) == 0);
        default:  m_tready <= cycle_count[2];
      endcase
    end
  end

  initial begin
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] pat;
    int r;
    // nothing created yet: id zero and an unissued id
    push_req(KIND_WAIT, 0, '1, 1'b1, 1'b1, 1'b0);
    push_req(KIND_SET, 1, 32'h1, 1'b0, 1'b0, 1'b0);
    push_req(KIND_CREATE, 0, '0, 1'b0, 1'b1, 1'b0);
    push_req(KIND_CREATE, 65535, '1, 1'b1, 1'b0, 1'b0);
    // empty pattern: AND mode met, OR mode not
    push_req(KIND_WAIT, 1, '0, 1'b1, 1'b0, 1'b0);
    push_req(KIND_WAIT, 1, '0, 1'b0, 1'b0, 1'b0);
    push_req(KIND_SET, 1, 32'h8000_0001, 1'b0, 1'b0, 1'b0);
    push_req(KIND_WAIT, 1, 32'h8000_0001, 1'b1, 1'b0, 1'b0);
    push_req(KIND_WAIT, 1, 32'h8000_0001, 1'b0, 1'b0, 1'b0);
    push_req(KIND_WAIT, 2, '1, 1'b1, 1'b0, 1'b0);
    push_req(KIND_CLEAR, 2, 32'h0000_FFFF, 1'b0, 1'b0, 1'b0);
    push_req(KIND_WAIT, 2, 32'hFFFF_0000, 1'b0, 1'b0, 1'b0);
    push_req(KIND_DELETE, 2, '0, 1'b0, 1'b0, 1'b0);
    push_req(KIND_WAIT, 2, '1, 1'b0, 1'b0, 1'b0);
    push_req(KIND_DELETE, 2, '0, 1'b0, 1'b0, 1'b0);
    push_req(KIND_SET, 65535, '1, 1'b1, 1'b1, 1'b0);
    push_req(KIND_CLEAR, TABLE_DEPTH, '0, 1'b0, 1'b0, 1'b0);
    push_req(3'd5, 1, '1, 1'b1, 1'b1, 1'b0);
    push_req(3'd6, 1, '0, 1'b0, 1'b0, 1'b0);
    push_req(3'd7, 1, 32'h5555_AAAA, 1'b1, 1'b0, 1'b0);
    push_req(KIND_CREATE, 0, 32'h10, 1'b0, 1'b1, 1'b0);
    push_req(KIND_WAIT, 3, 32'h10, 1'b0, 1'b0, 1'b0);
    push_req(KIND_WAIT, 3, 32'h10, 1'b0, 1'b0, 1'b0);

    for (int i = 0; i < RANDOM_OPS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 27) kind = KIND_CREATE;
      else if (r < 32) kind = KIND_DELETE;
      else if (r < 52) kind = KIND_SET;
      else if (r < 66) kind = KIND_CLEAR;
      else if (r < 96) kind = KIND_WAIT;
      else kind = KIND_W'($urandom_range(5, 7));
      pat = pick_pattern();
      if (kind == KIND_CLEAR && $urandom_range(0, 1)) pat = ~pat;
      push_req(kind, (kind == KIND_CREATE) ? $urandom_range(0, 65535) : pick_id(),
               pat, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               (i == 0 || i == RANDOM_OPS / 2));
    end
    // run the table dry, then knock on it
    while (gen_next < TABLE_DEPTH)
      push_req(KIND_CREATE, 0, $urandom, 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 1'b0);
    push_req(KIND_CREATE, 0, '1, 1'b1, 1'b1, 1'b0);
    push_req(KIND_CREATE, 0, '0, 1'b0, 1'b0, 1'b0);
    for (int i = 0; i < 6; i++)
      push_req(KIND_WAIT, pick_id(), pick_pattern(), 1'($urandom_range(0, 1)), 1'b0, 1'b0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (!(op_queue.size() == 0 && !s_tvalid && due_outcomes.size() == 0) &&
           cycle_count < LIMIT_CYCLES)
      @(negedge clk);
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d outcomes still due",
               cycle_count, due_outcomes.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      repeat (10) @(negedge clk);
      $display("ran %0d requests in %0d cycles, %0d results with %0d error status",
               n_sent, cycle_count, n_results, n_err_status);
      $display("%0d waits satisfied, %0d creates refused on a full table",
               n_satisfied, refused_creates);
      if (mismatch_count == 0) begin
        $display("CHECK OK");
      end else begin
        $display("%0d mismatches", mismatch_count);
        $display("CHECK FAILED");
      end
      $finish;
    end
  end

endmodule

/* sim.f */
design/eft_pkg.sv
design/eft_ram.sv
design/event_flag_table_top.sv
tb/sv/event_flag_table_top_test.sv
